// ===== hw/rtl/pkp_pkg.sv =====
// shared types, constants and helpers of the paced keystroke player
`timescale 1ns / 1ps
package pkp_pkg;

	localparam int TEXT_DEPTH_DEF = 4096;
	localparam int FIELD_LEN_DEF  = 8;

	localparam int KD_W   = 40;
	localparam int FP_W   = 20;
	localparam int IDF_W  = 16;
	localparam int MAG_W  = 45;
	localparam int HALF_W = 21;
	localparam int HPROD_W = HALF_W + FP_W;
	localparam int PROD_W = 2 * HALF_W + FP_W;

	localparam logic [FP_W-1:0]   FRAME_US_RESET = 20'd16667;
	localparam logic [KD_W-1:0]   DLY_MAX   = 40'h7F_FFFF_FFFF;
	localparam logic [KD_W-1:0]   DLY_MIN   = 40'h80_0000_0000;
	localparam logic [PROD_W-1:0] PROD_MAX  = 62'h7F_FFFF_FFFF;
	localparam logic [PROD_W-1:0] PROD_MAX1 = 62'h80_0000_0000;
	localparam logic [MAG_W-1:0]  MAG_CAP   = 45'h200_0000_0000;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic CFG_INITIAL_DELAY = 1'b0;
	localparam logic CFG_FRAME_PERIOD  = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [7:0]      text_byte;
		logic            text_first;
		logic            text_last;
		logic [FP_W-1:0] elapsed_us;
		logic            is_tick;
		logic            is_load_end;
	} pkp_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TERM, ST_RD0, ST_C0, ST_PK_W, ST_PK, ST_NM_W, ST_NM,
		ST_VL_W, ST_VL, ST_MUL0, ST_MUL1, ST_APPLY, ST_OUT
	} state_t;

	typedef enum logic [1:0] {CMD_NONE, CMD_WAIT, CMD_DELAY, CMD_KEY} cmd_t;

	typedef enum logic [1:0] {VP_WS, VP_DIG, VP_STOP} vp_t;

	function automatic logic [7:0] name_ch(input cmd_t c, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		unique case (c)
			CMD_WAIT: begin
				case (i)
					3'd0: r = 8'h77;
					3'd1: r = 8'h61;
					3'd2: r = 8'h69;
					3'd3: r = 8'h74;
					default: r = 8'h00;
				endcase
			end
			CMD_DELAY: begin
				case (i)
					3'd0: r = 8'h64;
					3'd1: r = 8'h65;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h61;
					3'd4: r = 8'h79;
					default: r = 8'h00;
				endcase
			end
			CMD_KEY: begin
				case (i)
					3'd0: r = 8'h6B;
					3'd1: r = 8'h65;
					3'd2: r = 8'h79;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/pkp_if.sv =====
// channel interfaces: input items, key words and configuration writes
`timescale 1ns / 1ps
interface pkp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] text_byte;
	logic       text_first;
	logic       text_last;
	logic [19:0] elapsed_us;
	modport source(output valid, kind, text_byte, text_first, text_last, elapsed_us,
		input ready);
	modport sink(input valid, kind, text_byte, text_first, text_last, elapsed_us,
		output ready);
endinterface

interface pkp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;
	modport source(output valid, key_code, input ready);
	modport sink(input valid, key_code, output ready);
endinterface

interface pkp_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [19:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pkp_front.sv =====
// front end: accepts and classifies input words into a two-entry queue
`timescale 1ns / 1ps
module pkp_front import pkp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pkp_in_if.sink    items,
	output logic      item_valid,
	output pkp_item_t item,
	input  logic      item_ready
);

	pkp_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	pkp_item_t  cls;

	assign items.ready = (count_q != 2'd2);
	assign push        = items.valid && items.ready;
	assign item_valid  = (count_q != 2'd0);
	assign item        = fifo_q[rd_ptr_q];
	assign pop         = item_valid && item_ready;

	always_comb begin
		cls.kind        = items.kind;
		cls.text_byte   = items.text_byte;
		cls.text_first  = items.text_first;
		cls.text_last   = items.text_last;
		cls.elapsed_us  = items.elapsed_us;
		cls.is_tick     = (items.kind == KIND_TICK);
		cls.is_load_end = (items.text_byte == 8'h00) || items.text_last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/pkp_back.sv =====
// back end: text store, playback sequencer, command parser and scaling
`timescale 1ns / 1ps
module pkp_back import pkp_pkg::*; #(
	parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
	parameter int FIELD_LEN  = FIELD_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  pkp_item_t item,
	output logic      item_ready,
	pkp_cfg_if.sink   cfg,
	pkp_out_if.source keys
);

	localparam int AW = $clog2(TEXT_DEPTH);
	localparam int PW = AW + 1;
	localparam int FW = $clog2(FIELD_LEN);

	logic [7:0] mem_q [TEXT_DEPTH];
	logic [7:0] rdata_q;

	state_t state_q, state_d;
	logic [PW-1:0] rp_q, wp_q, wp_eff;
	logic present_q, overflow_q, load_active_q, active_eff, room;
	logic signed [KD_W-1:0] wait_q, delay_q;
	logic [FP_W-1:0] fp_q;
	logic [7:0] c_q, key_q, byte_c, low_n, low_f;
	logic [7:0] low_q;
	logic keys_valid_q, slot_free, take;
	logic [FW-1:0] cnt_q;
	logic eq_wait_q, eq_delay_q, eq_key_q;
	cmd_t cmd_q, cmd_n;
	vp_t vp_q;
	logic neg_q, is_ws, is_dig, cnt_last;
	logic [MAG_W-1:0] mag_q, mag_n;
	logic [HPROD_W-1:0] plo_q, phi_q, mul_p;
	logic [HALF_W-1:0] mul_a;
	logic [PROD_W-1:0] prod;
	logic [KD_W-1:0] sat;
	logic [3:0] dig;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0] mem_wd;
	logic byte_write;

	assign byte_c     = present_q ? rdata_q : 8'h00;
	assign slot_free  = !keys_valid_q || keys.ready;
	assign take       = item_valid && item_ready;
	assign active_eff = item.text_first || load_active_q;
	assign wp_eff     = item.text_first ? '0 : wp_q;
	assign room       = ({1'b0, wp_eff} + (PW+1)'(3)) <= (PW+1)'(TEXT_DEPTH);
	assign byte_write = active_eff && item.text_byte != 8'h00;
	assign cnt_last   = (cnt_q == FW'(FIELD_LEN - 1));
	assign is_ws      = (byte_c == CH_SPACE) || (byte_c >= CH_TAB && byte_c <= CH_CR);
	assign is_dig     = (byte_c >= CH_ZERO) && (byte_c <= CH_NINE);
	assign dig        = 4'(byte_c - CH_ZERO);
	assign mag_n      = (mag_q < MAG_CAP) ?
		((mag_q << 3) + (mag_q << 1) + MAG_W'(dig)) : mag_q;
	assign low_n      = (low_q << 3) + (low_q << 1) + 8'(dig);
	assign low_f      = neg_q ? (8'h00 - low_q) : low_q;
	assign mul_a      = (state_q == ST_MUL0) ? mag_q[HALF_W-1:0]
		: mag_q[2*HALF_W-1:HALF_W];
	assign mul_p      = HPROD_W'(mul_a) * HPROD_W'(fp_q);
	assign prod       = {phi_q, {HALF_W{1'b0}}} + PROD_W'(plo_q);
	assign cfg.ready  = 1'b1;
	assign keys.valid    = keys_valid_q;
	assign keys.key_code = key_q;

	always_comb begin
		if (eq_wait_q && cnt_q == FW'(4)) cmd_n = CMD_WAIT;
		else if (eq_delay_q && cnt_q == FW'(5)) cmd_n = CMD_DELAY;
		else if (eq_key_q && cnt_q == FW'(3)) cmd_n = CMD_KEY;
		else cmd_n = CMD_NONE;
	end

	always_comb begin
		if (mag_q == '0 || fp_q == '0) sat = '0;
		else if (mag_q > MAG_CAP) sat = neg_q ? DLY_MIN : DLY_MAX;
		else if (!neg_q) sat = (prod > PROD_MAX) ? DLY_MAX : prod[KD_W-1:0];
		else sat = (prod > PROD_MAX1) ? DLY_MIN : (KD_W'(0) - prod[KD_W-1:0]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.is_tick) state_d = (wait_q > 0) ? ST_OUT : ST_RD0;
					else if (active_eff && item.is_load_end) state_d = ST_TERM;
				end
			end
			ST_TERM: state_d = ST_IDLE;
			ST_RD0:  state_d = ST_C0;
			ST_C0:   state_d = (byte_c == CH_DOLLAR || byte_c == CH_HASH) ? ST_PK_W : ST_OUT;
			ST_PK_W: state_d = ST_PK;
			ST_PK:   state_d = (byte_c == CH_LBRACE) ? ST_NM_W : ST_OUT;
			ST_NM_W: state_d = ST_NM;
			ST_NM: begin
				if (byte_c == CH_COLON) state_d = ST_VL_W;
				else if (cnt_last) state_d = ST_OUT;
				else state_d = ST_NM_W;
			end
			ST_VL_W: state_d = ST_VL;
			ST_VL: begin
				if (byte_c == CH_RBRACE) state_d = ST_MUL0;
				else if (cnt_last) state_d = ST_OUT;
				else state_d = ST_VL_W;
			end
			ST_MUL0:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_APPLY;
			ST_APPLY: state_d = ST_OUT;
			ST_OUT:   if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = wp_eff[AW-1:0];
		mem_wd     = item.text_byte;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				mem_we = item_valid && !item.is_tick && byte_write && room;
			end
			ST_TERM: begin
				mem_we = !overflow_q;
				mem_wa = wp_q[AW-1:0];
				mem_wd = 8'h00;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rdata_q <= mem_q[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rp_q          <= '0;
			wp_q          <= '0;
			present_q     <= 1'b0;
			overflow_q    <= 1'b0;
			load_active_q <= 1'b0;
			wait_q        <= '0;
			delay_q       <= '0;
			fp_q          <= FRAME_US_RESET;
			keys_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && slot_free) keys_valid_q <= 1'b1;
			else if (keys.ready) keys_valid_q <= 1'b0;
			if (cfg.valid) begin
				if (cfg.index == CFG_INITIAL_DELAY) begin
					delay_q <= KD_W'(cfg.data[IDF_W-1:0]) * KD_W'(fp_q);
				end else begin
					fp_q <= cfg.data;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take && !item.is_tick) begin
						if (item.text_first) begin
							load_active_q <= 1'b1;
							rp_q          <= '0;
							wait_q        <= '0;
							present_q     <= 1'b0;
						end
						if (byte_write && room) wp_q <= wp_eff + PW'(1);
						else if (item.text_first) wp_q <= '0;
						if (byte_write && !room) overflow_q <= 1'b1;
						else if (item.text_first) overflow_q <= 1'b0;
					end else if (take) begin
						if (wait_q > 0) wait_q <= wait_q - $signed(KD_W'(item.elapsed_us));
						else wait_q <= delay_q;
					end
				end
				ST_TERM: begin
					load_active_q <= 1'b0;
					if (overflow_q) begin
						present_q <= 1'b0;
						wp_q      <= '0;
					end else begin
						present_q <= 1'b1;
					end
				end
				ST_C0, ST_NM, ST_VL: begin
					if (byte_c != 8'h00) rp_q <= rp_q + PW'(1);
				end
				ST_PK: begin
					if (byte_c == CH_LBRACE) rp_q <= rp_q + PW'(1);
				end
				ST_APPLY: begin
					if (cmd_q == CMD_WAIT) wait_q <= sat;
					else if (cmd_q == CMD_DELAY) delay_q <= sat;
				end
				default: begin
				end
			endcase
		end
	end

	// command datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: c_q <= 8'h00;
			ST_C0:   c_q <= byte_c;
			ST_PK: begin
				cnt_q      <= '0;
				eq_wait_q  <= 1'b1;
				eq_delay_q <= 1'b1;
				eq_key_q   <= 1'b1;
			end
			ST_NM: begin
				if (byte_c == CH_COLON) begin
					cmd_q <= cmd_n;
					cnt_q <= '0;
					vp_q  <= VP_WS;
					neg_q <= 1'b0;
					mag_q <= '0;
					low_q <= 8'h00;
				end else begin
					eq_wait_q  <= eq_wait_q && cnt_q < FW'(4)
						&& byte_c == name_ch(CMD_WAIT, cnt_q[2:0]);
					eq_delay_q <= eq_delay_q && cnt_q < FW'(5)
						&& byte_c == name_ch(CMD_DELAY, cnt_q[2:0]);
					eq_key_q   <= eq_key_q && cnt_q < FW'(3)
						&& byte_c == name_ch(CMD_KEY, cnt_q[2:0]);
					cnt_q <= cnt_q + FW'(1);
					if (cnt_last) c_q <= 8'h00;
				end
			end
			ST_VL: begin
				if (byte_c != CH_RBRACE) begin
					cnt_q <= cnt_q + FW'(1);
					if (cnt_last) c_q <= 8'h00;
					unique case (vp_q)
						VP_WS: begin
							if (is_ws) begin
								vp_q <= VP_WS;
							end else if (byte_c == CH_PLUS || byte_c == CH_MINUS) begin
								neg_q <= (byte_c == CH_MINUS);
								vp_q  <= VP_DIG;
							end else if (is_dig) begin
								mag_q <= mag_n;
								low_q <= low_n;
								vp_q  <= VP_DIG;
							end else begin
								vp_q <= VP_STOP;
							end
						end
						VP_DIG: begin
							if (is_dig) begin
								mag_q <= mag_n;
								low_q <= low_n;
							end else begin
								vp_q <= VP_STOP;
							end
						end
						default: vp_q <= VP_STOP;
					endcase
				end
			end
			ST_MUL0: plo_q <= mul_p;
			ST_MUL1: phi_q <= mul_p;
			ST_APPLY: c_q <= (cmd_q == CMD_KEY) ? low_f : 8'h00;
			ST_OUT: begin
				if (slot_free) key_q <= (c_q == CH_LF) ? CH_CR : c_q;
			end
			default: begin
			end
		endcase
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> state_q == ST_IDLE) else $error("item taken while busy");
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wp_q} <= (PW+1)'(TEXT_DEPTH - 2)) else $error("write position overrun");
	a_rp_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		present_q |-> rp_q <= wp_q) else $error("read past terminator");
	a_emit_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(keys_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray key word");

endmodule

// ===== hw/rtl/paced_keystroke_player_core.sv =====
// top level of the paced keystroke player
`timescale 1ns / 1ps
// Text bytes (kind 0) load into the text store, one word per cycle while the back end is idle,
// and a TERM state then writes the terminator; ticks (kind 1) play the text back and each tick
// returns exactly one key word. A tick that only counts down its wait goes straight to output,
// a plain key reads one stored byte, and a ${name:value} command (also #{name:value}) walks its
// stored bytes, then the MUL0, MUL1 and APPLY states: the store has a single read port with
// registered data, and every byte the sequencer looks at costs an address and a data state.
// A two-word input queue keeps accepting, until full, while the back end works or a key word waits.
module paced_keystroke_player_core import pkp_pkg::*; #(
	parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
	parameter int FIELD_LEN  = FIELD_LEN_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pkp_in_if.sink    items,
	pkp_out_if.source keys,
	pkp_cfg_if.sink   cfg
);

	logic      item_valid;
	logic      item_ready;
	pkp_item_t item;

	pkp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	pkp_back #(
		.TEXT_DEPTH (TEXT_DEPTH),
		.FIELD_LEN  (FIELD_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.cfg        (cfg),
		.keys       (keys)
	);

endmodule
